// ===== rtl/core/sachm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sachm_pkg
// Shared widths, register indexes and constants of the cache hit model.
// ----------------------------------------------------------------------------
package sachm_pkg;

    // Request and response field widths.
    localparam int ADDR_W  = 32;
    localparam int TAG_W   = 30;
    localparam int SET_W   = 10;
    localparam int WAY_W   = 10;
    localparam int COUNT_W = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INDEX_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WAY_BITS   = 1'b1;

    // Configuration reset values.
    localparam logic [CFG_DATA_W-1:0] INDEX_BITS_RESET = 4'd8;
    localparam logic [CFG_DATA_W-1:0] WAY_BITS_RESET   = 4'd2;

    // Victim selection LFSR: Galois form, x^16+x^14+x^13+x^11+1.
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        logic [15:0] n;
        n = {1'b0, s[15:1]};
        if (s[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sachm_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sachm_req_if
// Request channel: one byte address per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sachm_req_if;
    import sachm_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sachm_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sachm_rsp_if
// Response channel: lookup outcome and running counters, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sachm_rsp_if;
    import sachm_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic [SET_W-1:0]   set_index;
    logic [WAY_W-1:0]   way;
    logic [COUNT_W-1:0] ref_count;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] miss_count;

    modport source (output valid, output hit, output set_index, output way,
                    output ref_count, output hit_count, output miss_count,
                    input ready);
    modport sink   (input valid, input hit, input set_index, input way,
                    input ref_count, input hit_count, input miss_count,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sachm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sachm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sachm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/set_assoc_cache_hit_model.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_hit_model
// Tag-only set-associative cache with pseudo-random replacement.
// ----------------------------------------------------------------------------
// Each request carries one byte address and gives one response. The response
// holds hit or miss, the set, the way that hit or was replaced, and running
// reference, hit and miss counts. Tags and valid bits share one RAM of
// ENTRIES words. The ways of a set are read one per cycle from its single
// read port, unless a pending response stalls the search, and compared as the
// data returns. A hit ends the search without reading the remaining ways.
// The block returns to idle, and can take the next request, in the same cycle
// as the response appears; it takes no new request while a search runs. A
// response that has not been taken holds back the decision on the next
// request. A miss writes the victim way in the cycle that decides it. After
// reset the RAM is swept once, entry by entry, to clear the valid bits.
// Requests are held off during the sweep, but configuration writes are taken.
// The user must write index_bits and way_bits only while the block is idle;
// the block itself does not enforce this. Stored tags are kept across a
// change and are read under the new layout.
// ----------------------------------------------------------------------------
module set_assoc_cache_hit_model #(
    parameter int ENTRIES   = 1024,
    parameter int ADDR_BITS = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [sachm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sachm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    sachm_req_if.sink                             req,
    sachm_rsp_if.source                           rsp
);
    import sachm_pkg::*;

    // Store limit: floor(log2(ENTRIES)), and the RAM address width.
    localparam int L  = $clog2(ENTRIES + 1) - 1;
    localparam int AW = $clog2(ENTRIES);
    localparam int MW = TAG_W + 1;
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                              : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [CFG_DATA_W-1:0] LIM = CFG_DATA_W'(L);
    localparam logic [AW-1:0] LAST_ENTRY = AW'(ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH
    } state_t;

    state_t               state_reg;
    logic [AW-1:0]        clr_idx_reg;
    logic [CFG_DATA_W-1:0] index_bits_reg;
    logic [CFG_DATA_W-1:0] way_bits_reg;
    logic [L-1:0]         set_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [CFG_DATA_W-1:0] wb_reg;
    logic [L:0]           rd_way_reg;
    logic                 cmp_valid_reg;
    logic [L-1:0]         cmp_way_reg;
    logic [15:0]          lfsr_reg;
    logic [COUNT_W-1:0]   ref_reg;
    logic [COUNT_W-1:0]   hit_reg;
    logic [COUNT_W-1:0]   miss_reg;
    logic                 rsp_valid_reg;
    logic                 rsp_hit_reg;
    logic [SET_W-1:0]     rsp_set_reg;
    logic [WAY_W-1:0]     rsp_way_reg;

    logic [ADDR_W-1:0]     addr_m;
    logic [CFG_DATA_W-1:0] wb_eff;
    logic [CFG_DATA_W-1:0] ib_eff;
    logic [L-1:0]          set_next;
    logic [TAG_W-1:0]      tag_next;
    logic [L:0]            ways;
    logic [L-1:0]          way_mask;
    logic [L-1:0]          base;
    logic [L-1:0]          victim;
    logic                  accept;
    logic                  out_free;
    logic                  stall;
    logic                  issue_more;
    logic                  match;
    logic                  decide;
    logic                  issue;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [MW-1:0]         mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [MW-1:0]         mem_rdata;

    // Split the address under the effective layout.
    always_comb
    begin
        addr_m   = req.address & ADDR_MASK;
        wb_eff   = (way_bits_reg > LIM) ? LIM : way_bits_reg;
        ib_eff   = (index_bits_reg > (LIM - wb_eff)) ? (LIM - wb_eff) : index_bits_reg;
        set_next = addr_m[L+1:2] & ~({L{1'b1}} << ib_eff);
        tag_next = TAG_W'(addr_m >> (6'd2 + 6'(ib_eff)));
    end

    // Search control: one read issued and one compare per cycle, unless a pending response stalls the search.
    always_comb
    begin
        ways       = (L+1)'(1) << wb_reg;
        way_mask   = L'(ways - (L+1)'(1));
        base       = set_reg << wb_reg;
        victim     = lfsr_reg[L-1:0] & way_mask;
        accept     = req.valid && req.ready;
        out_free   = !rsp_valid_reg || rsp.ready;
        stall      = cmp_valid_reg && !out_free;
        issue_more = (rd_way_reg != ways);
        match      = cmp_valid_reg && mem_rdata[TAG_W] && (mem_rdata[TAG_W-1:0] == tag_reg);
        decide     = (state_reg == ST_SEARCH) && !stall && cmp_valid_reg
                     && (match || !issue_more);
        issue      = (state_reg == ST_SEARCH) && !stall && !match && issue_more;
    end

    // RAM ports: the read address, and the clearing sweep or the victim write of a miss.
    always_comb
    begin
        mem_raddr = AW'(base | rd_way_reg[L-1:0]);
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = decide && !match;
            mem_waddr = AW'(base | victim);
            mem_wdata = {1'b1, tag_reg};
        end
    end

    sachm_ram #(
        .WIDTH (MW),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (issue),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // State, search registers, counters and the response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            index_bits_reg <= INDEX_BITS_RESET;
            way_bits_reg   <= WAY_BITS_RESET;
            set_reg        <= '0;
            tag_reg        <= '0;
            wb_reg         <= '0;
            rd_way_reg     <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_way_reg    <= '0;
            lfsr_reg       <= LFSR_SEED;
            ref_reg        <= '0;
            hit_reg        <= '0;
            miss_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_hit_reg    <= 1'b0;
            rsp_set_reg    <= '0;
            rsp_way_reg    <= '0;
        end
        else
        begin
            // Configuration writes.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_IDX_INDEX_BITS: index_bits_reg <= cfg_wdata;
                    CFG_IDX_WAY_BITS:   way_bits_reg   <= cfg_wdata;
                    default:            ;
                endcase
            end

            // The response leaves when taken.
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + AW'(1);
                    if (clr_idx_reg == LAST_ENTRY)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        set_reg       <= set_next;
                        tag_reg       <= tag_next;
                        wb_reg        <= wb_eff;
                        rd_way_reg    <= '0;
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (!stall)
                    begin
                        cmp_valid_reg <= issue;
                        if (issue)
                        begin
                            cmp_way_reg <= rd_way_reg[L-1:0];
                            rd_way_reg  <= rd_way_reg + (L+1)'(1);
                        end
                    end
                    if (decide)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_hit_reg   <= match;
                        rsp_set_reg   <= SET_W'(set_reg);
                        ref_reg       <= ref_reg + COUNT_W'(1);
                        if (match)
                        begin
                            rsp_way_reg <= WAY_W'(cmp_way_reg);
                            hit_reg     <= hit_reg + COUNT_W'(1);
                        end
                        else
                        begin
                            rsp_way_reg <= WAY_W'(victim);
                            miss_reg    <= miss_reg + COUNT_W'(1);
                            lfsr_reg    <= lfsr_step(lfsr_reg);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    // Port drive.
    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.hit        = rsp_hit_reg;
    assign rsp.set_index  = rsp_set_reg;
    assign rsp.way        = rsp_way_reg;
    assign rsp.ref_count  = ref_reg;
    assign rsp.hit_count  = hit_reg;
    assign rsp.miss_count = miss_reg;

    // Every reference is counted as exactly one hit or one miss.
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ref_reg == hit_reg + miss_reg)
        else $error("reference count differs from hits plus misses");

    // A miss response always advances the victim LFSR.
    a_miss_steps_lfsr: assert property (@(posedge clk) disable iff (!rst_n)
        (decide && !match) |=> (lfsr_reg != $past(lfsr_reg)))
        else $error("victim LFSR did not advance on a miss");

    // The RAM is written only by the sweep or by a miss decision.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == ST_CLEAR) || (decide && !match)))
        else $error("unexpected tag RAM write");

    // The read pointer never runs past the ways of the set.
    a_way_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (rd_way_reg <= ways))
        else $error("way read pointer beyond the set");

    // A result is never produced while an earlier one would be lost.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        decide |-> out_free)
        else $error("response register overwritten");

endmodule
`default_nettype wire
